### design/nearest_trail_point_backtrack_defines.svh
// Assertion macros for the nearest trail point backtrack block.
// Used by the port checker; needs a clk_i and rst_ni in scope.
`ifndef NEAREST_TRAIL_POINT_BACKTRACK_DEFINES_SVH
`define NEAREST_TRAIL_POINT_BACKTRACK_DEFINES_SVH

// Property checked at every clock edge outside reset
`define NTPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next
`define NTPB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### design/ntpb_pkg.sv
// Shared types and constants for the nearest trail point backtrack block.
// No dependencies; used by controller, datapath, top level and checker.
package ntpb_pkg;

  localparam int COORD_BITS     = 24;
  localparam int ORIENT_BITS    = 32;
  localparam int OUT_INDEX_BITS = 6;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_PLAN   = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TRAIL = 1'b1
  } kind_e;

  // Input word
  typedef struct packed {
    opcode_e                       opcode;
    logic                          first_point;
    logic signed [COORD_BITS-1:0]  pose_x;
    logic signed [COORD_BITS-1:0]  pose_y;
    logic        [ORIENT_BITS-1:0] pose_orientation;
    logic signed [COORD_BITS-1:0]  goal_x;
    logic signed [COORD_BITS-1:0]  goal_y;
  } in_word_t;

  // Result word
  typedef struct packed {
    kind_e                            pose_kind;
    logic signed [COORD_BITS-1:0]     out_x;
    logic signed [COORD_BITS-1:0]     out_y;
    logic        [ORIENT_BITS-1:0]    out_orientation;
    logic        [OUT_INDEX_BITS-1:0] out_index;
    logic                             last;
    logic                             success;
  } out_word_t;

  // One stored trail point
  typedef struct packed {
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic        [ORIENT_BITS-1:0] orient;
  } trail_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic append;      // store the input word as a trail point
    logic plan;        // capture start and goal, clear the search
    logic search_run;  // walk the trail through the distance pipeline
    logic emit_begin;  // present the start pose, issue the newest point
    logic emit_run;    // keep emitting trail points
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic search_done;  // all points compared, best point settled
    logic plan_done;    // final word of the plan is on the outputs
  } sts_t;

endpackage

### design/ntpb_ctrl.sv
// Sequencer for the nearest trail point backtrack block.
// Depends on ntpb_pkg for the command and status structs.
module ntpb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ntpb_pkg::opcode_e opcode_i,
  input  ntpb_pkg::sts_t    sts_i,
  output ntpb_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT_START,
    ST_EMIT_TRAIL
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_i == ntpb_pkg::OP_PLAN)) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts_i.search_done) state_d = ST_EMIT_START;
      end
      ST_EMIT_START: begin
        state_d = ST_EMIT_TRAIL;
      end
      ST_EMIT_TRAIL: begin
        if (sts_i.plan_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.append     = (state_q == ST_IDLE) && accept && (opcode_i == ntpb_pkg::OP_APPEND);
    cmd_o.plan       = (state_q == ST_IDLE) && accept && (opcode_i == ntpb_pkg::OP_PLAN);
    cmd_o.search_run = (state_q == ST_SEARCH);
    cmd_o.emit_begin = (state_q == ST_EMIT_START);
    cmd_o.emit_run   = (state_q == ST_EMIT_TRAIL);
  end

  // State and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

### design/ntpb_datapath.sv
// Trail memory, distance pipeline, best point tracker and output register.
// Depends on ntpb_pkg; driven by ntpb_ctrl through cmd_t and sts_t.
module ntpb_datapath #(
  parameter int unsigned TRAIL_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntpb_pkg::cmd_t      cmd_i,
  input  ntpb_pkg::in_word_t  item_i,
  output ntpb_pkg::sts_t      sts_o,
  output ntpb_pkg::out_word_t result_o,
  output logic                result_valid_o
);

  localparam int IDX_W  = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TRAIL_DEPTH + 1);
  localparam int DIFF_W = ntpb_pkg::COORD_BITS + 1;
  localparam int DIST_W = 2 * DIFF_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TRAIL_DEPTH);

  // Trail memory and its registered read word
  ntpb_pkg::trail_entry_t mem_q [TRAIL_DEPTH];
  ntpb_pkg::trail_entry_t rd_q;
  ntpb_pkg::trail_entry_t wr_entry;
  logic                   wr_en, rd_en;
  logic [IDX_W-1:0]       wr_addr, rd_addr;

  // Captured plan request
  ntpb_pkg::trail_entry_t           start_q;
  logic signed [ntpb_pkg::COORD_BITS-1:0] goal_x_q, goal_y_q;

  // Control state
  logic [CNT_W-1:0]  count_q, ptr_q, cnt_m1;
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [IDX_W-1:0]  s1_tag_q, s2_tag_q, s3_tag_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_dist_q;
  logic              emore_q, ev_q, out_valid_q;

  // Search pipeline payload
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [DIFF_W-1:0]        adx_d, ady_d, dx_q, dy_q;
  logic [DIST_W-1:0]        sqx_q, sqy_q, dist_sum;

  // Emission payload
  logic [IDX_W-1:0]    eidx_q, etag_q, e_addr;
  logic                elast_q;
  logic                s_issue, e_issue, out_valid_d;
  ntpb_pkg::out_word_t out_d, out_q;

  // Write port: a first point restarts at index 0, a full trail drops points
  assign wr_en    = cmd_i.append && (item_i.first_point || (count_q < DEPTH_C));
  assign wr_addr  = item_i.first_point ? '0 : count_q[IDX_W-1:0];
  assign wr_entry = '{x: item_i.pose_x, y: item_i.pose_y, orient: item_i.pose_orientation};

  // Read port shared by the search walk and the emission walk
  assign cnt_m1  = count_q - CNT_W'(1);
  assign s_issue = cmd_i.search_run && (ptr_q < count_q);
  assign e_issue = cmd_i.emit_begin ? (count_q != '0) : (cmd_i.emit_run && emore_q);
  assign e_addr  = cmd_i.emit_begin ? cnt_m1[IDX_W-1:0] : eidx_q;
  assign rd_en   = s_issue || e_issue;
  assign rd_addr = e_issue ? e_addr : ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_entry;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Absolute coordinate differences to the goal
  assign diff_x = DIFF_W'(rd_q.x) - DIFF_W'(goal_x_q);
  assign diff_y = DIFF_W'(rd_q.y) - DIFF_W'(goal_y_q);
  assign adx_d  = diff_x[DIFF_W-1] ? (~diff_x + 1'b1) : diff_x;
  assign ady_d  = diff_y[DIFF_W-1] ? (~diff_y + 1'b1) : diff_y;

  // Squared distance, compared in the last stage
  assign dist_sum = sqx_q + sqy_q;

  // Output word
  always_comb begin
    out_d = out_q;
    if (cmd_i.emit_begin) begin
      out_d.pose_kind       = ntpb_pkg::KIND_START;
      out_d.out_x           = start_q.x;
      out_d.out_y           = start_q.y;
      out_d.out_orientation = start_q.orient;
      out_d.out_index       = '0;
      out_d.last            = (count_q == '0);
      out_d.success         = (count_q != '0);
    end else begin
      out_d.pose_kind       = ntpb_pkg::KIND_TRAIL;
      out_d.out_x           = rd_q.x;
      out_d.out_y           = rd_q.y;
      out_d.out_orientation = rd_q.orient;
      out_d.out_index       = ntpb_pkg::OUT_INDEX_BITS'(etag_q);
      out_d.last            = elast_q;
      out_d.success         = 1'b1;
    end
  end

  assign out_valid_d = cmd_i.emit_begin || ev_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '1;
      emore_q     <= 1'b0;
      ev_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        if (item_i.first_point) count_q <= CNT_W'(1);
        else if (count_q < DEPTH_C) count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.plan) begin
        ptr_q       <= '0;
        best_idx_q  <= '0;
        best_dist_q <= '1;
      end else begin
        if (s_issue) ptr_q <= ptr_q + CNT_W'(1);
        // strict compare keeps the lowest index on a tie
        if (s3_v_q && (dist_sum < best_dist_q)) begin
          best_dist_q <= dist_sum;
          best_idx_q  <= s3_tag_q;
        end
      end
      s1_v_q <= s_issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      // emission stops once the nearest point has been issued
      if (e_issue) emore_q <= (e_addr != best_idx_q);
      else if (cmd_i.emit_begin) emore_q <= 1'b0;
      ev_q        <= e_issue;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      start_q  <= '{x: item_i.pose_x, y: item_i.pose_y, orient: item_i.pose_orientation};
      goal_x_q <= item_i.goal_x;
      goal_y_q <= item_i.goal_y;
    end
    if (s_issue) s1_tag_q <= ptr_q[IDX_W-1:0];
    s2_tag_q <= s1_tag_q;
    s3_tag_q <= s2_tag_q;
    dx_q     <= adx_d;
    dy_q     <= ady_d;
    sqx_q    <= dx_q * dx_q;
    sqy_q    <= dy_q * dy_q;
    if (e_issue) begin
      etag_q  <= e_addr;
      elast_q <= (e_addr == best_idx_q);
      eidx_q  <= e_addr - IDX_W'(1);
    end
    if (out_valid_d) out_q <= out_d;
  end

  assign sts_o.search_done = (ptr_q == count_q) && !s1_v_q && !s2_v_q && !s3_v_q;
  assign sts_o.plan_done   = out_valid_q && out_q.last;

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule

### design/nearest_trail_point_backtrack.sv
// Append word: busy stays low, no result; next word can follow at once.
// Plan word over N >= 1 stored points emitting M trail points: busy until the final word;
// all N points are searched, then the start pose and one trail point per cycle follow,
// newest first down to the nearest. Empty trail: start pose alone. Results cannot be held off.
// The single read port of the trail memory is walked in full to search, then newest to nearest to emit.
// Reset (async, low) empties the trail; memory contents are not cleared.
module nearest_trail_point_backtrack #(
  parameter int unsigned TRAIL_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ntpb_pkg::in_word_t  item_i,
  output logic                busy,
  output ntpb_pkg::out_word_t result_o,
  output logic                result_valid_o
);

  ntpb_pkg::cmd_t cmd;
  ntpb_pkg::sts_t sts;

  // Sequencer
  ntpb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Trail storage and arithmetic
  ntpb_datapath #(
    .TRAIL_DEPTH (TRAIL_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

### design/ntpb_checker.sv
// Port-level checker for the nearest trail point backtrack block, with its bind.
// Depends on ntpb_pkg and nearest_trail_point_backtrack_defines.svh.
`include "nearest_trail_point_backtrack_defines.svh"

module ntpb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input ntpb_pkg::in_word_t  item_i,
  input logic                busy,
  input ntpb_pkg::out_word_t result_o,
  input logic                result_valid_o
);

  // Results only come out while a plan is running
  `NTPB_ASSERT(a_result_in_plan, !result_valid_o || busy, "result word outside a plan")

  // A plan word raises busy, an append word leaves it low
  `NTPB_ASSERT_NEXT(a_plan_busy, start && !busy && (item_i.opcode == ntpb_pkg::OP_PLAN), busy, "plan word did not raise busy")
  `NTPB_ASSERT_NEXT(a_append_idle, start && !busy && (item_i.opcode == ntpb_pkg::OP_APPEND), !busy, "append word raised busy")

  // Nothing follows the final word of a plan
  `NTPB_ASSERT_NEXT(a_last_ends, result_valid_o && result_o.last, !result_valid_o && !busy, "word after the final pose")

  // A trail point in a plan always means success
  `NTPB_ASSERT(a_trail_success, !(result_valid_o && (result_o.pose_kind == ntpb_pkg::KIND_TRAIL)) || result_o.success, "trail point without success")

endmodule

bind nearest_trail_point_backtrack ntpb_checker u_ntpb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .item_i         (item_i),
  .busy           (busy),
  .result_o       (result_o),
  .result_valid_o (result_valid_o)
);
